>>> hdl/slp_pkg.sv
// Shared types and constants for the struct field layout packer.
// Holds the controller/datapath command and status words and the status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package slp_pkg;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_WIDTH = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;

  localparam int unsigned ALIGN_W = 16;

  typedef struct packed {
    logic take;
    logic div_start;
    logic div_sel;
    logic round;
    logic place;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic need_align;
    logic div_done;
    logic last;
    logic out_free;
  } sts_t;

  function automatic logic [1:0] raise_code(input logic [1:0] cur, input logic [1:0] code);
    return (cur == ST_OK) ? code : cur;
  endfunction

endpackage

`default_nettype wire

>>> hdl/slp_if.sv
// Channel interfaces of the struct field layout packer.
// slp_in_if carries one field description per word, slp_out_if one placement result.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface slp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] field_bytes;
  logic [15:0] align_bytes;
  logic [7:0]  bf_width;
  logic [15:0] type_id;
  logic        last_field;

  modport source (output valid, field_bytes, align_bytes, bf_width, type_id, last_field,
                  input ready);
  modport sink (input valid, field_bytes, align_bytes, bf_width, type_id, last_field,
                output ready);
endinterface

interface slp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] byte_pos;
  logic [7:0]  bit_pos;
  logic [1:0]  status;
  logic [31:0] struct_size;
  logic [15:0] struct_align;
  logic        is_last;

  modport source (output valid, byte_pos, bit_pos, status, struct_size, struct_align,
                  is_last, input ready);
  modport sink (input valid, byte_pos, bit_pos, status, struct_size, struct_align,
                is_last, output ready);
endinterface

`default_nettype wire

>>> hdl/slp_modulo.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Used by the layout datapath for alignment rounding. Depends on slp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slp_modulo #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [OFFSET_BITS-1:0]     dividend,
  input  wire logic [slp_pkg::ALIGN_W-1:0] divisor,
  output logic                            idle,
  output logic [slp_pkg::ALIGN_W-1:0]     rem
);
  import slp_pkg::*;

  localparam int unsigned CW = $clog2(OFFSET_BITS + 1);

  logic                   busy;
  logic [CW-1:0]          cnt;
  logic [OFFSET_BITS-1:0] dvd;
  logic [ALIGN_W-1:0]     dsr;
  logic [ALIGN_W-1:0]     rem_r;
  logic [ALIGN_W:0]       rem_shift;
  logic [ALIGN_W:0]       rem_sub;
  logic                   ge;

  assign rem_shift = {rem_r, dvd[OFFSET_BITS-1]};
  assign ge        = rem_shift >= {1'b0, dsr};
  assign rem_sub   = rem_shift - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(OFFSET_BITS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd   <= dividend;
      dsr   <= divisor;
      rem_r <= '0;
    end else if (busy) begin
      dvd   <= dvd << 1;
      rem_r <= ge ? rem_sub[ALIGN_W-1:0] : rem_shift[ALIGN_W-1:0];
    end
  end

  assign idle = !busy;
  assign rem  = rem_r;

endmodule

`default_nettype wire

>>> hdl/slp_datapath.sv
// Layout datapath: captured field, layout state, rounding adders and output register.
// Driven by slp_ctrl through cmd_t; depends on slp_pkg, slp_if and slp_modulo.
`timescale 1ns / 1ps
`default_nettype none

module slp_datapath #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire slp_pkg::cmd_t cmd,
  output slp_pkg::sts_t      sts,
  slp_in_if.sink             fields,
  slp_out_if.source          results
);
  import slp_pkg::*;

  localparam int unsigned SW = ((OFFSET_BITS > 32) ? OFFSET_BITS : 32) + 1;
  localparam logic [OFFSET_BITS-1:0] LIM = {OFFSET_BITS{1'b1}};
  localparam logic [SW-1:0] LIM_EXT = SW'(LIM);

  // Layout state.
  logic [OFFSET_BITS-1:0] run_off;
  logic [OFFSET_BITS-1:0] unit_stop;
  logic [ALIGN_W-1:0]     largest;
  logic [34:0]            unit_cap;
  logic [34:0]            unit_fill;
  logic                   unit_open;
  logic [15:0]            unit_tid;
  logic [1:0]             err;

  // Captured word and working registers.
  logic [31:0]            it_bytes;
  logic [ALIGN_W-1:0]     it_align;
  logic [7:0]             it_width;
  logic [15:0]            it_tid;
  logic                   it_last;
  logic [OFFSET_BITS-1:0] pos_r;
  logic [OFFSET_BITS-1:0] pos_keep;
  logic [7:0]             bit_keep;

  // Output register.
  logic        out_valid;
  logic [31:0] ob_byte;
  logic [7:0]  ob_bit;
  logic [1:0]  ob_status;
  logic [31:0] ob_size;
  logic [15:0] ob_align;
  logic        ob_last;

  logic                   capture;
  logic [OFFSET_BITS-1:0] base;
  logic [OFFSET_BITS-1:0] fin;
  logic [34:0]            storage;
  logic                   bad_width;
  logic [35:0]            join_sum;
  logic                   open_fresh;
  logic [OFFSET_BITS-1:0] div_dvd;
  logic [ALIGN_W-1:0]     div_dsr;
  logic                   div_idle;
  logic [ALIGN_W-1:0]     rem;
  logic [SW-1:0]          rnd_sum;
  logic                   rnd_ovf;
  logic [SW-1:0]          fb_sum;
  logic                   fb_ovf;
  logic [OFFSET_BITS-1:0] fb_sat;
  logic [SW-1:0]          size_sum;
  logic                   size_ovf;
  logic [OFFSET_BITS-1:0] size_val;
  logic                   size_raise;
  logic [ALIGN_W-1:0]     align_max;
  logic [34:0]            used_src;
  logic                   bit_big;
  logic [7:0]             bit_val;
  logic [34:0]            used_new;
  logic [34:0]            cap_src;
  logic [OFFSET_BITS-1:0] end_src;
  logic [OFFSET_BITS-1:0] run_src;
  logic                   closes;
  logic [1:0]             st_fin;

  assign capture = cmd.take && fields.valid;

  assign base       = (run_off > unit_stop) ? run_off : unit_stop;
  assign fin        = unit_open ? unit_stop : run_off;
  assign storage    = {it_bytes, 3'b000};
  assign bad_width  = (it_width != 8'd0) && ((it_bytes == 32'd0) || (35'(it_width) > storage));
  assign join_sum   = 36'(unit_fill) + 36'(it_width);
  assign open_fresh = !unit_open || (it_tid != unit_tid) || (join_sum > 36'(storage));

  assign div_dvd = cmd.div_sel ? fin : base;
  assign div_dsr = cmd.div_sel ? largest : it_align;

  slp_modulo #(.OFFSET_BITS(OFFSET_BITS)) u_modulo (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .idle     (div_idle),
    .rem      (rem)
  );

  assign rnd_sum = SW'(base) + SW'(it_align - rem);
  assign rnd_ovf = rnd_sum > LIM_EXT;

  assign fb_sum = SW'(pos_r) + SW'(it_bytes);
  assign fb_ovf = fb_sum > LIM_EXT;
  assign fb_sat = fb_ovf ? LIM : fb_sum[OFFSET_BITS-1:0];

  assign size_sum   = SW'(fin) + SW'(largest - rem);
  assign size_ovf   = size_sum > LIM_EXT;
  assign size_raise = (rem != '0) && size_ovf;
  assign size_val   = (rem == '0) ? fin : (size_ovf ? LIM : size_sum[OFFSET_BITS-1:0]);
  assign st_fin     = (it_last && size_raise) ? raise_code(err, ST_OVERFLOW) : err;

  assign align_max = (it_align > largest) ? it_align : largest;
  assign used_src  = open_fresh ? 35'd0 : unit_fill;
  assign bit_big   = used_src > 35'd255;
  assign bit_val   = bit_big ? 8'hFF : used_src[7:0];
  assign used_new  = used_src + 35'(it_width);
  assign cap_src   = open_fresh ? storage : unit_cap;
  assign end_src   = open_fresh ? fb_sat : unit_stop;
  assign run_src   = open_fresh ? pos_r : run_off;
  assign closes    = used_new == cap_src;

  always_ff @(posedge clk) begin
    if (rst || (cmd.emit && it_last)) begin
      run_off   <= '0;
      unit_stop <= '0;
      largest   <= ALIGN_W'(1);
      unit_cap  <= '0;
      unit_fill <= '0;
      unit_open <= 1'b0;
      unit_tid  <= '0;
      err       <= ST_OK;
    end else if (cmd.round) begin
      if ((rem != '0) && rnd_ovf) begin
        err <= raise_code(err, ST_OVERFLOW);
      end
    end else if (cmd.place) begin
      if (it_width == 8'd0) begin
        largest   <= align_max;
        unit_open <= 1'b0;
        unit_fill <= '0;
        unit_cap  <= '0;
        run_off   <= fb_sat;
        unit_stop <= fb_sat;
        if (fb_ovf) begin
          err <= raise_code(err, ST_OVERFLOW);
        end
      end else if (bad_width) begin
        err <= raise_code(err, ST_BAD_WIDTH);
      end else begin
        largest   <= align_max;
        unit_stop <= end_src;
        unit_cap  <= cap_src;
        if (open_fresh) begin
          unit_tid <= it_tid;
        end
        if ((open_fresh && fb_ovf) || bit_big) begin
          err <= raise_code(err, ST_OVERFLOW);
        end
        if (closes) begin
          run_off   <= end_src;
          unit_open <= 1'b0;
          unit_fill <= '0;
        end else begin
          run_off   <= run_src;
          unit_open <= 1'b1;
          unit_fill <= used_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      it_bytes <= fields.field_bytes;
      it_align <= (fields.align_bytes == '0) ? ALIGN_W'(1) : fields.align_bytes;
      it_width <= fields.bf_width;
      it_tid   <= fields.type_id;
      it_last  <= fields.last_field;
    end
    if (cmd.round) begin
      if (rem == '0) begin
        pos_r <= base;
      end else begin
        pos_r <= rnd_ovf ? LIM : rnd_sum[OFFSET_BITS-1:0];
      end
    end
    if (cmd.place) begin
      if (it_width == 8'd0) begin
        pos_keep <= pos_r;
        bit_keep <= 8'd0;
      end else if (bad_width) begin
        pos_keep <= base;
        bit_keep <= 8'd0;
      end else begin
        pos_keep <= run_src;
        bit_keep <= bit_val;
      end
    end
    if (cmd.emit) begin
      ob_byte   <= 32'(pos_keep);
      ob_bit    <= bit_keep;
      ob_status <= st_fin;
      ob_size   <= it_last ? 32'(size_val) : 32'd0;
      ob_align  <= it_last ? largest : 16'd0;
      ob_last   <= it_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign fields.ready         = cmd.take;
  assign results.valid        = out_valid;
  assign results.byte_pos     = ob_byte;
  assign results.bit_pos      = ob_bit;
  assign results.status       = ob_status;
  assign results.struct_size  = ob_size;
  assign results.struct_align = ob_align;
  assign results.is_last      = ob_last;

  assign sts.in_valid   = fields.valid;
  assign sts.need_align = (it_width == 8'd0) || (!bad_width && open_fresh);
  assign sts.div_done   = div_idle;
  assign sts.last       = it_last;
  assign sts.out_free   = !out_valid || results.ready;

  // A new result is loaded only into a free output register.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || results.ready))
    else $error("result loaded over an unread word");

  // An open storage unit always has a nonzero capacity.
  a_open_cap: assert property (@(posedge clk) disable iff (rst)
    unit_open |-> (unit_cap != 35'd0))
    else $error("open unit without capacity");

  // The struct alignment never drops to zero.
  a_align_nz: assert property (@(posedge clk) disable iff (rst)
    largest != '0)
    else $error("largest alignment is zero");

  // A raised status holds until the struct ends.
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    ((err != ST_OK) && !(cmd.emit && it_last)) |=> (err == $past(err)))
    else $error("status code changed before the last field");

  // The output register only carries defined status codes.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((ob_status == ST_OK) || (ob_status == ST_BAD_WIDTH) ||
                   (ob_status == ST_OVERFLOW)))
    else $error("undefined status code");

endmodule

`default_nettype wire

>>> hdl/slp_ctrl.sv
// Controller state machine of the struct field layout packer.
// Sequences capture, remainder, rounding, placement and emit; depends on slp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire slp_pkg::sts_t sts,
  output slp_pkg::cmd_t      cmd
);
  import slp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV1,
    S_ROUND,
    S_PLACE,
    S_FIN,
    S_DIV2,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.take = 1'b1;
        if (sts.in_valid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.need_align) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV1;
        end else begin
          state_next = S_PLACE;
        end
      end
      S_DIV1: begin
        if (sts.div_done) begin
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.round  = 1'b1;
        state_next = S_PLACE;
      end
      S_PLACE: begin
        cmd.place  = 1'b1;
        state_next = sts.last ? S_FIN : S_EMIT;
      end
      S_FIN: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
        state_next    = S_DIV2;
      end
      S_DIV2: begin
        if (sts.div_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/struct_field_layout_packer_top.sv
// Top level of the struct field layout packer: controller plus datapath.
// Depends on slp_pkg, slp_if, slp_ctrl and slp_datapath.
//
//   Channel   Dir  Word                                                   Accepted when
//   fields    in   field_bytes, align_bytes, bf_width, type_id, last_field valid && ready
//   results   out  byte_pos, bit_pos, status, struct_size,                valid && ready
//                  struct_align, is_last
//
// One field at a time. A plain field, or a bitfield that opens a new unit, is reported
// after the one-bit-per-cycle remainder unit and the rounding step; a bitfield joining an
// open unit, or a bad bitfield, skips both and goes straight to placement.
// The next field can be accepted from the cycle after the result is loaded. The last field
// runs the remainder unit a second time for the struct size.
// Reset is synchronous and leaves an empty layout.
// The output register lets the next field be accepted while a result waits to be read.
`timescale 1ns / 1ps
`default_nettype none

module struct_field_layout_packer_top #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  slp_in_if.sink    fields,
  slp_out_if.source results
);
  import slp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  slp_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  slp_datapath #(.OFFSET_BITS(OFFSET_BITS)) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .sts     (sts),
    .fields  (fields),
    .results (results)
  );

endmodule

`default_nettype wire

>>> tb/struct_field_layout_packer_top_tb.sv
// Self-checking testbench for struct_field_layout_packer_top.
// Predicts each field placement and struct summary in SystemVerilog and checks every result
// word; depends on slp_pkg, slp_if and the packer RTL.
`timescale 1ns / 1ps

module struct_field_layout_packer_top_tb;
  import slp_pkg::*;

  localparam int unsigned OFFSET_BITS = 32;
  localparam logic [63:0] OFFSET_MAX = (64'd1 << OFFSET_BITS) - 64'd1;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES = 2 * (2 * OFFSET_BITS + 7);

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [31:0] field_bytes;
    logic [15:0] align_bytes;
    logic [7:0]  bf_width;
    logic [15:0] type_id;
    logic        last_field;
  } field_word_t;

  typedef struct packed {
    logic [31:0] byte_pos;
    logic [7:0]  bit_pos;
    logic [1:0]  status;
    logic [31:0] struct_size;
    logic [15:0] struct_align;
    logic        is_last;
  } placement_t;

  logic clk;
  logic rst;

  slp_in_if  fields ();
  slp_out_if results ();

  struct_field_layout_packer_top #(.OFFSET_BITS(OFFSET_BITS)) dut (
    .clk     (clk),
    .rst     (rst),
    .fields  (fields),
    .results (results)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  idle_mode_t  idle_mode = IDLE_NONE;
  placement_t  placements_due[$];
  int unsigned fail_count = 0;
  int unsigned fields_sent = 0;
  int unsigned idle_cycles = 0;

  int unsigned common_bytes[8] = '{1, 2, 4, 8, 3, 6, 12, 16};
  int unsigned common_align[8] = '{1, 2, 4, 8, 3, 6, 4, 0};

  logic [31:0] lay_running;
  logic [31:0] lay_unit_stop;
  logic [15:0] lay_largest_align;
  logic [15:0] lay_unit_type;
  logic [34:0] lay_unit_cap;
  logic [34:0] lay_unit_fill;
  logic        lay_unit_open;
  logic [1:0]  lay_status;

  function automatic void clear_layout();
    lay_running = '0;
    lay_unit_stop = '0;
    lay_largest_align = 16'd1;
    lay_unit_type = '0;
    lay_unit_cap = '0;
    lay_unit_fill = '0;
    lay_unit_open = 1'b0;
    lay_status = ST_OK;
  endfunction

  function automatic void flag_status(input logic [1:0] code);
    if (lay_status == ST_OK) begin
      lay_status = code;
    end
  endfunction

  function automatic logic [63:0] offset_add(input logic [63:0] a, input logic [63:0] b);
    if (a > OFFSET_MAX || b > OFFSET_MAX - a) begin
      flag_status(ST_OVERFLOW);
      return OFFSET_MAX;
    end
    return a + b;
  endfunction

  function automatic logic [63:0] round_to(input logic [63:0] v, input logic [63:0] a);
    logic [63:0] rem;
    if (a <= 64'd1) begin
      return v;
    end
    rem = v % a;
    if (rem == 0) begin
      return v;
    end
    return offset_add(v, a - rem);
  endfunction

  function automatic placement_t place_field(input field_word_t f);
    logic [63:0] fb;
    logic [63:0] fa;
    logic [63:0] w;
    logic [63:0] base;
    logic [63:0] pos;
    logic [63:0] storage;
    logic [63:0] bitpos;
    logic [63:0] fin;
    placement_t  r;
    r = '0;
    fb = 64'(f.field_bytes);
    fa = (f.align_bytes == 0) ? 64'd1 : 64'(f.align_bytes);
    w = 64'(f.bf_width);
    bitpos = '0;
    base = (lay_running > lay_unit_stop) ? 64'(lay_running) : 64'(lay_unit_stop);
    if (w == 0) begin
      lay_unit_open = 1'b0;
      lay_unit_fill = '0;
      lay_unit_cap = '0;
      pos = round_to(base, fa);
      if (fa > 64'(lay_largest_align)) begin
        lay_largest_align = fa[15:0];
      end
      lay_running = 32'(offset_add(pos, fb));
      lay_unit_stop = lay_running;
    end else begin
      storage = fb * 64'd8;
      if (storage == 0 || w > storage) begin
        flag_status(ST_BAD_WIDTH);
        pos = base;
      end else begin
        if (fa > 64'(lay_largest_align)) begin
          lay_largest_align = fa[15:0];
        end
        if (!lay_unit_open || f.type_id != lay_unit_type ||
            64'(lay_unit_fill) + w > storage) begin
          pos = round_to(base, fa);
          lay_running = pos[31:0];
          lay_unit_type = f.type_id;
          lay_unit_cap = storage[34:0];
          lay_unit_fill = '0;
          lay_unit_open = 1'b1;
          lay_unit_stop = 32'(offset_add(pos, fb));
        end
        pos = 64'(lay_running);
        bitpos = 64'(lay_unit_fill);
        if (bitpos > 64'd255) begin
          flag_status(ST_OVERFLOW);
          bitpos = 64'd255;
        end
        lay_unit_fill = 35'(64'(lay_unit_fill) + w);
        if (lay_unit_fill == lay_unit_cap) begin
          lay_running = lay_unit_stop;
          lay_unit_open = 1'b0;
          lay_unit_fill = '0;
        end
      end
    end
    if (f.last_field) begin
      fin = lay_unit_open ? 64'(lay_unit_stop) : 64'(lay_running);
      r.struct_size = 32'(round_to(fin, 64'(lay_largest_align)));
      r.struct_align = lay_largest_align;
    end
    r.byte_pos = pos[31:0];
    r.bit_pos = bitpos[7:0];
    r.status = lay_status;
    r.is_last = f.last_field;
    if (f.last_field) begin
      clear_layout();
    end
    return r;
  endfunction

  function automatic field_word_t fw(input logic [31:0] b, input logic [15:0] a,
                                     input logic [7:0] w, input logic [15:0] t, input logic l);
    fw = '{field_bytes: b, align_bytes: a, bf_width: w, type_id: t, last_field: l};
  endfunction

  function automatic field_word_t random_field();
    field_word_t f;
    int unsigned k;
    int unsigned max_w;
    if ($urandom_range(99) < 85) begin
      k = $urandom_range(7);
      f.field_bytes = common_bytes[k];
      f.align_bytes = ($urandom_range(7) == 0) ? 16'($urandom_range(0, 24)) :
                                                 16'(common_align[k]);
      f.type_id = ($urandom_range(9) == 0) ? 16'($urandom_range(0, 7)) : 16'(k);
      max_w = (8 * common_bytes[k] > 255) ? 255 : 8 * common_bytes[k];
      f.bf_width = ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom_range(1, max_w));
    end else begin
      f.field_bytes = ($urandom_range(1) == 0) ? $urandom : $urandom_range(0, 64);
      f.align_bytes = 16'($urandom_range(0, 65535));
      f.bf_width = 8'($urandom_range(0, 255));
      f.type_id = 16'($urandom_range(0, 65535));
    end
    f.last_field = 1'b0;
    return f;
  endfunction

  task automatic send_field(input field_word_t f);
    int unsigned gap_pct;
    gap_pct = (idle_mode == IDLE_SENDER) ? 57 : (idle_mode == IDLE_BOTH) ? 31 : 0;
    if ($urandom_range(99) < gap_pct) begin
      fields.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    fields.valid <= 1'b1;
    fields.field_bytes <= f.field_bytes;
    fields.align_bytes <= f.align_bytes;
    fields.bf_width <= f.bf_width;
    fields.type_id <= f.type_id;
    fields.last_field <= f.last_field;
    @(posedge clk);
    while (!fields.ready) begin
      @(posedge clk);
    end
    placements_due.push_back(place_field(f));
    fields_sent++;
  endtask

  task automatic wait_for_results();
    fields.valid <= 1'b0;
    while (placements_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic test_plain_fields();
    send_field(fw(32'd1, 16'd1, 8'd0, 16'd1, 1'b0));
    send_field(fw(32'd4, 16'd4, 8'd0, 16'd2, 1'b0));
    send_field(fw(32'd3, 16'd3, 8'd0, 16'd3, 1'b0));
    send_field(fw(32'd2, 16'd0, 8'd0, 16'd4, 1'b0));
    send_field(fw(32'd0, 16'd5, 8'd0, 16'd0, 1'b1));
    send_field(fw(32'd8, 16'hFFFF, 8'd0, 16'hFFFF, 1'b1));
    wait_for_results();
  endtask

  task automatic test_bitfield_packing();
    send_field(fw(32'd4, 16'd4, 8'd3, 16'd10, 1'b0));
    send_field(fw(32'd4, 16'd4, 8'd5, 16'd10, 1'b0));
    send_field(fw(32'd4, 16'd4, 8'd24, 16'd10, 1'b0));
    send_field(fw(32'd4, 16'd4, 8'd1, 16'd10, 1'b0));
    send_field(fw(32'd2, 16'd2, 8'd4, 16'd11, 1'b0));
    send_field(fw(32'd1, 16'd1, 8'd0, 16'd0, 1'b0));
    send_field(fw(32'd2, 16'd2, 8'd9, 16'd12, 1'b0));
    send_field(fw(32'd1, 16'd1, 8'd7, 16'd12, 1'b0));
    send_field(fw(32'd2, 16'd2, 8'd7, 16'd12, 1'b1));
    send_field(fw(32'd32, 16'd2, 8'd255, 16'hFFFF, 1'b1));
    wait_for_results();
  endtask

  task automatic test_bad_bitfield();
    send_field(fw(32'd0, 16'd4, 8'd1, 16'd1, 1'b0));
    send_field(fw(32'd1, 16'd1, 8'd9, 16'd1, 1'b0));
    send_field(fw(32'd4, 16'd4, 8'd0, 16'd2, 1'b1));
    wait_for_results();
  endtask

  task automatic test_offset_overflow();
    send_field(fw(32'hFFFF_FFF0, 16'd1, 8'd0, 16'd0, 1'b0));
    send_field(fw(32'h0000_0020, 16'd4, 8'd0, 16'd0, 1'b0));
    send_field(fw(32'hFFFF_FFFF, 16'hFFFE, 8'd0, 16'd0, 1'b1));
    send_field(fw(32'd1, 16'd8, 8'd0, 16'd0, 1'b0));
    send_field(fw(32'hFFFF_FFFE, 16'd1, 8'd0, 16'd0, 1'b1));
    wait_for_results();
  endtask

  task automatic test_wide_unit_bit_offset();
    send_field(fw(32'd64, 16'd8, 8'd200, 16'd5, 1'b0));
    send_field(fw(32'd64, 16'd8, 8'd200, 16'd5, 1'b0));
    send_field(fw(32'd64, 16'd8, 8'd100, 16'd5, 1'b0));
    send_field(fw(32'd1, 16'd1, 8'd0, 16'd0, 1'b1));
    wait_for_results();
  endtask

  task automatic test_random_layouts(input idle_mode_t mode, input int unsigned count);
    int unsigned stop_at;
    int unsigned n_fields;
    field_word_t f;
    idle_mode = mode;
    stop_at = fields_sent + count;
    while (fields_sent < stop_at) begin
      n_fields = $urandom_range(1, 10);
      for (int i = 0; i < n_fields; i++) begin
        f = random_field();
        f.last_field = (i == n_fields - 1);
        send_field(f);
      end
    end
    wait_for_results();
    idle_mode = IDLE_NONE;
  endtask

  initial begin
    results.ready <= 1'b0;
    forever begin
      @(posedge clk);
      case (idle_mode)
        IDLE_RECEIVER: begin
          results.ready <= ($urandom_range(99) >= 57);
        end
        IDLE_BOTH: begin
          results.ready <= ($urandom_range(99) >= 31);
        end
        default: begin
          results.ready <= 1'b1;
        end
      endcase
    end
  end

  always @(posedge clk) begin
    placement_t want;
    if (!rst && results.valid && results.ready) begin
      if (placements_due.size() == 0) begin
        if (fail_count < 10) begin
          $display("unexpected result word: off=%0h bit=%0d st=%0d size=%0h algn=%0d last=%0b",
                   results.byte_pos, results.bit_pos, results.status,
                   results.struct_size, results.struct_align, results.is_last);
        end
        fail_count++;
      end else begin
        want = placements_due.pop_front();
        if (results.byte_pos !== want.byte_pos || results.bit_pos !== want.bit_pos ||
            results.status !== want.status || results.struct_size !== want.struct_size ||
            results.struct_align !== want.struct_align || results.is_last !== want.is_last) begin
          if (fail_count < 10) begin
            $display("mismatch: expected off=%0h bit=%0d st=%0d size=%0h algn=%0d last=%0b",
                     want.byte_pos, want.bit_pos, want.status, want.struct_size,
                     want.struct_align, want.is_last);
            $display("          actual   off=%0h bit=%0d st=%0d size=%0h algn=%0d last=%0b",
                     results.byte_pos, results.bit_pos, results.status,
                     results.struct_size, results.struct_align, results.is_last);
          end
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((fields.valid && fields.ready) || (results.valid && results.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  initial begin
    clear_layout();
    rst <= 1'b1;
    fields.valid <= 1'b0;
    fields.field_bytes <= '0;
    fields.align_bytes <= '0;
    fields.bf_width <= '0;
    fields.type_id <= '0;
    fields.last_field <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_plain_fields();
    test_bitfield_packing();
    test_bad_bitfield();
    test_offset_overflow();
    test_wide_unit_bit_offset();
    test_random_layouts(IDLE_NONE, 350);
    test_random_layouts(IDLE_SENDER, 350);
    test_random_layouts(IDLE_RECEIVER, 350);
    test_random_layouts(IDLE_BOTH, 350);
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && placements_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
